// ===== src/kwt_pkg.sv =====
// Shared types and constants of the key whitelist table.
package kwt_pkg;

    // Field widths of the stream payloads.
    localparam int KEY_LO_W    = 64;
    localparam int KEY_HI_W    = 32;
    localparam int IN_DATA_W   = 96;
    localparam int OUT_DATA_W  = 16;
    localparam int COUNT_OUT_W = 7;
    localparam int RESULT_W    = 11;

    // A 96-bit key; the lower word sits in the low bits.
    typedef struct packed {
        logic [KEY_HI_W-1:0] hi;
        logic [KEY_LO_W-1:0] lo;
    } t_key;

    // The two admin keys that the table holds from reset.
    localparam t_key ADMIN_KEY0 = '{hi: 32'hFFFF_FFFF, lo: 64'hFFFF_FFFF_FFFF_FFFF};
    localparam t_key ADMIN_KEY1 = '{hi: 32'hCCCC_CCCC, lo: 64'hCCCC_CCCC_CCCC_CCCC};

    // Strobes from the sequencer to the key store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    // One result, authorized in the lowest bit.
    typedef struct packed {
        logic [COUNT_OUT_W-1:0] stored_count;
        logic                   table_full;
        logic                   added;
        logic                   is_admin;
        logic                   authorized;
    } t_result;

endpackage

// ===== src/kwt_mem.sv =====
// Key store: one write port, one registered read port, admin entries fixed.
module kwt_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                 i_clk,
    input  kwt_pkg::t_mem_ctl    i_ctl,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  kwt_pkg::t_key        i_wr_data,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    output kwt_pkg::t_key        o_rd_data
);

    kwt_pkg::t_key     r_mem [DEPTH];
    kwt_pkg::t_key     r_rd_data;
    logic [ADDR_W-1:0] r_rd_addr;

    // Appends only ever land at the third entry or later.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Synchronous read: the data is registered and appears in the cycle after the read strobe.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // The first two entries are the reset admin keys and are never rewritten.
    always_comb begin
        if (r_rd_addr == ADDR_W'(0)) begin
            o_rd_data = kwt_pkg::ADMIN_KEY0;
        end else if (r_rd_addr == ADDR_W'(1)) begin
            o_rd_data = kwt_pkg::ADMIN_KEY1;
        end else begin
            o_rd_data = r_rd_data;
        end
    end

endmodule

// ===== src/kwt_scan.sv =====
// Request sequencer: table scan for lookups, append for adds, result register.
module kwt_scan #(
    parameter int MAX_KEYS      = 64,
    parameter int ADMIN_ENTRIES = 2,
    parameter int CNT_W         = 7,
    parameter int ADDR_W        = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic                  i_mode,
    input  kwt_pkg::t_key         i_key,
    output kwt_pkg::t_mem_ctl     o_mem_ctl,
    output logic [ADDR_W-1:0]     o_wr_addr,
    output kwt_pkg::t_key         o_wr_data,
    output logic [ADDR_W-1:0]     o_rd_addr,
    input  kwt_pkg::t_key         i_rd_data,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output kwt_pkg::t_result      o_result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_cmp_vld, n_cmp_vld;
    logic [ADDR_W-1:0] r_cmp_idx, n_cmp_idx;
    kwt_pkg::t_key     r_key, n_key;
    logic              r_auth, n_auth;
    logic              r_admin, n_admin;
    logic              r_added, n_added;
    logic              r_full, n_full;
    logic              r_out_vld, n_out_vld;
    kwt_pkg::t_result  r_out, n_out;

    logic                   accept;
    logic                   issue;
    logic                   match;
    logic                   admin_hit;
    logic                   room;
    logic                   out_free;
    logic [CNT_W+6:0]       count_ext;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign issue      = (r_state == ST_SCAN) && (r_idx < r_count);
    assign match      = r_cmp_vld && (i_rd_data == r_key);
    assign admin_hit  = match && (32'(r_cmp_idx) < ADMIN_ENTRIES);
    assign room       = (r_count < CNT_W'(MAX_KEYS));
    assign out_free   = !r_out_vld || i_m_tready;
    assign count_ext  = {7'd0, r_count};

    // Memory accesses: one read per scan cycle while unread entries remain, one write per append.
    always_comb begin
        o_mem_ctl.rd_en = issue;
        o_mem_ctl.wr_en = (r_state == ST_ADD) && room;
        o_rd_addr       = r_idx[ADDR_W-1:0];
        o_wr_addr       = r_count[ADDR_W-1:0];
        o_wr_data       = r_key;
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_key     = r_key;
        n_auth    = r_auth;
        n_admin   = r_admin;
        n_added   = r_added;
        n_full    = r_full;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        n_cmp_vld = issue;
        n_cmp_idx = r_idx[ADDR_W-1:0];

        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_key   = i_key;
                    n_idx   = '0;
                    n_auth  = 1'b0;
                    n_admin = 1'b0;
                    n_added = 1'b0;
                    n_full  = 1'b0;
                    n_state = i_mode ? ST_ADD : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (match) begin
                    n_auth = 1'b1;
                end
                if (admin_hit) begin
                    n_admin = 1'b1;
                end
                // Leave once every entry has been read and compared.
                if (!issue && !r_cmp_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_ADD: begin
                if (room) begin
                    n_count = r_count + CNT_W'(1);
                    n_added = 1'b1;
                end else begin
                    n_full = 1'b1;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // Wait here until the result register is free.
                if (out_free) begin
                    n_out_vld          = 1'b1;
                    n_out.authorized   = r_auth;
                    n_out.is_admin     = r_admin;
                    n_out.added        = r_added;
                    n_out.table_full   = r_full;
                    n_out.stored_count = count_ext[6:0];
                    n_state            = ST_IDLE;
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= CNT_W'(2);
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_key     <= n_key;
        r_auth    <= n_auth;
        r_admin   <= n_admin;
        r_added   <= n_added;
        r_full    <= n_full;
        r_out     <= n_out;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_result   = r_out;

endmodule

// ===== src/key_whitelist_table_top.sv =====
// Key whitelist table: 96-bit key lookup and append over a scanned key store.
// Lookup: one memory read per stored key, then the result is registered.
// Add: the key is appended in the ADD state and the result is registered from the DONE state.
// One request is in progress at a time; the next is taken once its result is registered.
// Synchronous active-low reset restores the two admin keys and sets the count to two;
// no clearing pass is needed.
module key_whitelist_table_top #(
    parameter int MAX_KEYS      = 64,
    parameter int ADMIN_ENTRIES = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // key_low [63:0], key_high [95:64]
    input  logic [kwt_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // mode [0]: 0 = check, 1 = add
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // authorized [0], is_admin [1], added [2], table_full [3], stored_count [10:4], zeros [15:11]
    output logic [kwt_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);

    localparam int CNT_W  = $clog2(MAX_KEYS + 1);
    localparam int ADDR_W = $clog2(MAX_KEYS);

    kwt_pkg::t_mem_ctl  mem_ctl;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    kwt_pkg::t_key      wr_data;
    kwt_pkg::t_key      rd_data;
    kwt_pkg::t_key      in_key;
    kwt_pkg::t_result   result;

    assign in_key = kwt_pkg::t_key'(i_s_axis_tdata);

    kwt_mem #(
        .DEPTH  (MAX_KEYS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    kwt_scan #(
        .MAX_KEYS      (MAX_KEYS),
        .ADMIN_ENTRIES (ADMIN_ENTRIES),
        .CNT_W         (CNT_W),
        .ADDR_W        (ADDR_W)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_mode     (i_s_axis_tuser),
        .i_key      (in_key),
        .o_mem_ctl  (mem_ctl),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_result   (result)
    );

    assign o_m_axis_tdata = {(kwt_pkg::OUT_DATA_W - kwt_pkg::RESULT_W)'(0), result};

    // A scan never reads in the cycle of an append.
    a_no_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("key store read and written in the same cycle");

    // Appends never overwrite the admin keys held from reset.
    a_wr_above_admin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.wr_en |-> (32'(wr_addr) >= 2))
        else $error("append aimed at a reset admin entry");

    // A result reports either lookup flags or append flags, never both, and never added with table_full.
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !((result.authorized || result.is_admin)
                              && (result.added || result.table_full))
                            && !(result.added && result.table_full))
        else $error("result mixes lookup and append flags");

    // An admin match is always also an authorized match.
    a_admin_auth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && result.is_admin) |-> result.authorized)
        else $error("admin match without authorized match");

endmodule
